FILE: sv/chd_pkg.sv
// Shared types and constants for the chained hash dictionary.
// No dependencies; every other file refers to this package by scoped names.
package chd_pkg;

   localparam int BUCKETS = 1024;
   localparam int NODES   = 1024;

   localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int CNT_W  = $clog2(NODES + 1);
   localparam int MOD_W  = $clog2(BUCKETS + 1);

   localparam int CMD_W = 2;
   localparam int KEY_W = 64;
   localparam int VAL_W = 32;
   localparam int POS_W = 10;
   localparam int ST_W  = 3;
   localparam int ENT_W = 11;
   localparam int HSZ_W = 11;
   localparam int SUM_W = KEY_W / 2 + 1;

   localparam logic [HSZ_W-1:0] HSZ_RESET = 11'd1024;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_FIND   = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   typedef enum logic [ST_W-1:0] {
      ST_ADDED    = 3'd0,
      ST_UPDATED  = 3'd1,
      ST_FOUND    = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_FULL     = 3'd4,
      ST_CLEARED  = 3'd5,
      ST_READOK   = 3'd6,
      ST_PASTEND  = 3'd7
   } status_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [KEY_W-1:0]   key;
      logic [VAL_W-1:0]   value_a;
      logic [VAL_W-1:0]   value_b;
      logic [VAL_W-1:0]   value_c;
      logic [POS_W-1:0]   position;
      logic [SUM_W-1:0]   sum;
   } job_type;

   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] sum;
   } mod_req_type;

   typedef struct packed {
      logic             done;
      logic [BKT_W-1:0] bucket;
   } mod_rsp_type;

endpackage

FILE: sv/chd_ifs.sv
// Request and response channel interfaces of the chained hash dictionary.
// Depends on chd_pkg for field widths.
interface chd_req_if;
   logic                        valid;
   logic                        ready;
   logic [chd_pkg::CMD_W-1:0]   command;
   logic [chd_pkg::KEY_W-1:0]   key;
   logic [chd_pkg::VAL_W-1:0]   value_a;
   logic [chd_pkg::VAL_W-1:0]   value_b;
   logic [chd_pkg::VAL_W-1:0]   value_c;
   logic [chd_pkg::POS_W-1:0]   position;

   modport source(output valid, command, key, value_a, value_b, value_c, position,
                  input ready);
   modport sink(input valid, command, key, value_a, value_b, value_c, position,
                output ready);
endinterface

interface chd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [chd_pkg::ST_W-1:0]    status;
   logic [chd_pkg::KEY_W-1:0]   key_out;
   logic [chd_pkg::VAL_W-1:0]   value_a_out;
   logic [chd_pkg::VAL_W-1:0]   value_b_out;
   logic [chd_pkg::VAL_W-1:0]   value_c_out;
   logic [chd_pkg::POS_W-1:0]   position_out;
   logic [chd_pkg::ENT_W-1:0]   entry_count;

   modport source(output valid, status, key_out, value_a_out, value_b_out, value_c_out,
                  position_out, entry_count, input ready);
   modport sink(input valid, status, key_out, value_a_out, value_b_out, value_c_out,
                position_out, entry_count, output ready);
endinterface

FILE: sv/chd_front.sv
// Front end: accepts request transactions, decodes them and precomputes the
// key fold, then holds them in a two-entry queue. Depends on chd_pkg, chd_ifs.
module chd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   chd_req_if.sink           req_chan,
   output logic              job_valid,
   input  logic              job_ready,
   output chd_pkg::job_type  job
);
   localparam int QDEPTH = 2;

   chd_pkg::job_type q_ff [QDEPTH];
   logic             wr_ff, wr_in;
   logic             rd_ff, rd_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push, pop;
   chd_pkg::job_type entry;

   assign req_chan.ready = enable && (cnt_ff != 2'(QDEPTH));
   assign job_valid      = (cnt_ff != 2'd0);
   assign job            = q_ff[rd_ff];
   assign push           = req_chan.valid && req_chan.ready;
   assign pop            = job_valid && job_ready;

   always_comb begin
      entry.cmd      = chd_pkg::cmd_type'(req_chan.command);
      entry.key      = req_chan.key;
      entry.value_a  = req_chan.value_a;
      entry.value_b  = req_chan.value_b;
      entry.value_c  = req_chan.value_c;
      entry.position = req_chan.position;
      entry.sum      = chd_pkg::SUM_W'(req_chan.key[chd_pkg::KEY_W/2-1:0])
                     + chd_pkg::SUM_W'(req_chan.key[chd_pkg::KEY_W-1:chd_pkg::KEY_W/2]);
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= entry;
      end
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

FILE: sv/chd_mod.sv
// Bucket count register and bit-serial modulo unit (one quotient bit a cycle).
// Depends on chd_pkg.
module chd_mod (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [chd_pkg::HSZ_W-1:0]   csr_data,
   input  chd_pkg::mod_req_type        mod_req,
   output chd_pkg::mod_rsp_type        mod_rsp
);
   localparam int STEP_W = $clog2(chd_pkg::SUM_W + 1);

   logic [chd_pkg::HSZ_W-1:0] hsize_ff, hsize_in;
   logic [chd_pkg::MOD_W-1:0] rem_ff, rem_in;
   logic [chd_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [STEP_W-1:0]         cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [chd_pkg::MOD_W-1:0] modulus;
   logic [chd_pkg::MOD_W:0]   trial;

   assign csr_ready      = 1'b1;
   assign mod_rsp.done   = done_ff;
   assign mod_rsp.bucket = rem_ff[chd_pkg::BKT_W-1:0];
   assign trial          = {rem_ff, sum_ff[chd_pkg::SUM_W-1]};

   always_comb begin
      if (hsize_ff == '0) begin
         modulus = chd_pkg::MOD_W'(1);
      end else if (32'(hsize_ff) > chd_pkg::BUCKETS) begin
         modulus = chd_pkg::MOD_W'(chd_pkg::BUCKETS);
      end else begin
         modulus = chd_pkg::MOD_W'(hsize_ff);
      end

      hsize_in = csr_valid ? csr_data : hsize_ff;
      rem_in   = rem_ff;
      sum_in   = sum_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (mod_req.start) begin
         rem_in  = '0;
         sum_in  = mod_req.sum;
         cnt_in  = STEP_W'(chd_pkg::SUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, modulus}) begin
            rem_in = chd_pkg::MOD_W'(trial - {1'b0, modulus});
         end else begin
            rem_in = trial[chd_pkg::MOD_W-1:0];
         end
         sum_in = {sum_ff[chd_pkg::SUM_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sum_ff <= sum_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         hsize_ff <= chd_pkg::HSZ_RESET;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         hsize_ff <= hsize_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end
endmodule

FILE: sv/chd_back.sv
// Back end: bucket head and node stores, chain walk, insert/update, clear
// sweep and the response register. Depends on chd_pkg, chd_ifs.
module chd_back (
   input  logic                    clock,
   input  logic                    reset,
   output logic                    ready_en,
   input  logic                    job_valid,
   output logic                    job_ready,
   input  chd_pkg::job_type        job,
   output chd_pkg::mod_req_type    mod_req,
   input  chd_pkg::mod_rsp_type    mod_rsp,
   chd_rsp_if.source               rsp_chan
);
   localparam int NW = chd_pkg::NODE_W;
   localparam int BW = chd_pkg::BKT_W;
   localparam int VW = chd_pkg::VAL_W;

   typedef enum logic [2:0] {
      S_INIT, S_IDLE, S_SWEEP, S_HASH, S_HEAD, S_WALK, S_NODE, S_READ
   } state_type;

   logic [NW:0]             heads [chd_pkg::BUCKETS];
   logic [chd_pkg::KEY_W-1:0] keys [chd_pkg::NODES];
   logic [NW:0]             links [chd_pkg::NODES];
   logic [3*VW-1:0]         vals  [chd_pkg::NODES];

   state_type                  state_ff, state_in;
   chd_pkg::job_type           job_ff, job_in;
   logic [chd_pkg::CNT_W-1:0]  fill_ff, fill_in;
   logic [BW-1:0]              bucket_ff, bucket_in;
   logic [NW-1:0]              cur_ff, cur_in;
   logic                       ok_ff, ok_in;
   logic [chd_pkg::CNT_W-1:0]  steps_ff, steps_in;
   logic [NW:0]                link_ff, link_in;
   logic [BW-1:0]              sweep_ff, sweep_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   chd_pkg::status_type        status_ff, status_in;
   logic [chd_pkg::KEY_W-1:0]  key_out_ff, key_out_in;
   logic [VW-1:0]              va_ff, va_in, vb_ff, vb_in, vc_ff, vc_in;
   logic [chd_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [chd_pkg::ENT_W-1:0]  count_ff, count_in;

   logic [NW:0]                head_rd_ff;
   logic [chd_pkg::KEY_W-1:0]  key_rd_ff;
   logic [NW:0]                link_rd_ff;
   logic [3*VW-1:0]            val_rd_ff;

   logic                       head_we;
   logic [BW-1:0]              head_waddr, head_raddr;
   logic [NW:0]                head_wdata;
   logic                       node_we, val_we;
   logic [NW-1:0]              node_waddr, node_raddr;
   logic [3*VW-1:0]            val_wdata;

   assign ready_en              = (state_ff != S_INIT);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = status_ff;
   assign rsp_chan.key_out      = key_out_ff;
   assign rsp_chan.value_a_out  = va_ff;
   assign rsp_chan.value_b_out  = vb_ff;
   assign rsp_chan.value_c_out  = vc_ff;
   assign rsp_chan.position_out = pos_ff;
   assign rsp_chan.entry_count  = count_ff;

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      fill_in   = fill_ff;
      bucket_in = bucket_ff;
      cur_in    = cur_ff;
      ok_in     = ok_ff;
      steps_in  = steps_ff;
      link_in   = link_ff;
      sweep_in  = sweep_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      status_in    = status_ff;
      key_out_in   = key_out_ff;
      va_in        = va_ff;
      vb_in        = vb_ff;
      vc_in        = vc_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;

      job_ready     = 1'b0;
      mod_req.start = 1'b0;
      mod_req.sum   = job.sum;
      head_we       = 1'b0;
      head_waddr    = bucket_ff;
      head_wdata    = '0;
      head_raddr    = mod_rsp.bucket;
      node_we       = 1'b0;
      val_we        = 1'b0;
      node_waddr    = cur_ff;
      node_raddr    = cur_ff;
      val_wdata     = {job_ff.value_a, job_ff.value_b, job_ff.value_c};

      case (state_ff)
         S_INIT, S_SWEEP: begin
            head_we    = 1'b1;
            head_waddr = sweep_ff;
            sweep_in   = sweep_ff + 1'b1;
            if (sweep_ff == BW'(chd_pkg::BUCKETS - 1)) begin
               sweep_in = '0;
               state_in = S_IDLE;
               if (state_ff == S_SWEEP) begin
                  rsp_valid_in = 1'b1;
                  status_in    = chd_pkg::ST_CLEARED;
                  key_out_in   = '0;
                  va_in        = '0;
                  vb_in        = '0;
                  vc_in        = '0;
                  pos_in       = '0;
                  count_in     = '0;
               end
            end
         end
         S_IDLE: begin
            node_raddr = NW'(job.position);
            if (job_valid && !rsp_valid_ff) begin
               job_ready = 1'b1;
               job_in    = job;
               cur_in    = NW'(job.position);
               case (job.cmd)
                  chd_pkg::CMD_INSERT, chd_pkg::CMD_FIND: begin
                     mod_req.start = 1'b1;
                     state_in      = S_HASH;
                  end
                  chd_pkg::CMD_CLEAR: begin
                     fill_in  = '0;
                     sweep_in = '0;
                     state_in = S_SWEEP;
                  end
                  default: begin
                     if (32'(job.position) < 32'(fill_ff) &&
                         32'(job.position) < chd_pkg::NODES) begin
                        state_in = S_READ;
                     end else begin
                        rsp_valid_in = 1'b1;
                        status_in    = chd_pkg::ST_PASTEND;
                        key_out_in   = '0;
                        va_in        = '0;
                        vb_in        = '0;
                        vc_in        = '0;
                        pos_in       = '0;
                        count_in     = chd_pkg::ENT_W'(fill_ff);
                     end
                  end
               endcase
            end
         end
         S_HASH: begin
            if (mod_rsp.done) begin
               bucket_in = mod_rsp.bucket;
               state_in  = S_HEAD;
            end
         end
         S_HEAD: begin
            cur_in   = head_rd_ff[NW-1:0];
            ok_in    = head_rd_ff[NW];
            link_in  = head_rd_ff;
            steps_in = '0;
            state_in = S_WALK;
         end
         S_WALK: begin
            if (!ok_ff || 32'(steps_ff) >= chd_pkg::NODES ||
                32'(cur_ff) >= 32'(fill_ff)) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               key_out_in   = '0;
               va_in        = '0;
               vb_in        = '0;
               vc_in        = '0;
               pos_in       = '0;
               count_in     = chd_pkg::ENT_W'(fill_ff);
               if (job_ff.cmd == chd_pkg::CMD_FIND) begin
                  status_in = chd_pkg::ST_NOTFOUND;
               end else if (32'(fill_ff) >= chd_pkg::NODES) begin
                  status_in = chd_pkg::ST_FULL;
               end else begin
                  node_we    = 1'b1;
                  node_waddr = NW'(fill_ff);
                  head_we    = 1'b1;
                  head_wdata = {1'b1, NW'(fill_ff)};
                  fill_in    = fill_ff + 1'b1;
                  status_in  = chd_pkg::ST_ADDED;
                  key_out_in = job_ff.key;
                  va_in      = job_ff.value_a;
                  vb_in      = job_ff.value_b;
                  vc_in      = job_ff.value_c;
                  pos_in     = chd_pkg::POS_W'(fill_ff);
                  count_in   = chd_pkg::ENT_W'(fill_ff + 1'b1);
               end
            end else begin
               state_in = S_NODE;
            end
         end
         S_NODE: begin
            if (key_rd_ff == job_ff.key) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               key_out_in   = key_rd_ff;
               pos_in       = chd_pkg::POS_W'(cur_ff);
               count_in     = chd_pkg::ENT_W'(fill_ff);
               if (job_ff.cmd == chd_pkg::CMD_FIND) begin
                  status_in = chd_pkg::ST_FOUND;
                  va_in     = val_rd_ff[3*VW-1:2*VW];
                  vb_in     = val_rd_ff[2*VW-1:VW];
                  vc_in     = val_rd_ff[VW-1:0];
               end else begin
                  val_we    = 1'b1;
                  status_in = chd_pkg::ST_UPDATED;
                  va_in     = job_ff.value_a;
                  vb_in     = job_ff.value_b;
                  vc_in     = job_ff.value_c;
               end
            end else begin
               ok_in    = link_rd_ff[NW];
               cur_in   = link_rd_ff[NW-1:0];
               steps_in = steps_ff + 1'b1;
               state_in = S_WALK;
            end
         end
         S_READ: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            status_in    = chd_pkg::ST_READOK;
            key_out_in   = key_rd_ff;
            va_in        = val_rd_ff[3*VW-1:2*VW];
            vb_in        = val_rd_ff[2*VW-1:VW];
            vc_in        = val_rd_ff[VW-1:0];
            pos_in       = chd_pkg::POS_W'(cur_ff);
            count_in     = chd_pkg::ENT_W'(fill_ff);
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         heads[head_waddr] <= head_wdata;
      end
      head_rd_ff <= heads[head_raddr];
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         keys[node_waddr] <= job_ff.key;
      end
      key_rd_ff <= keys[node_raddr];
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         links[node_waddr] <= link_ff;
      end
      link_rd_ff <= links[node_raddr];
   end

   always_ff @(posedge clock) begin
      if (node_we || val_we) begin
         vals[node_waddr] <= val_wdata;
      end
      val_rd_ff <= vals[node_raddr];
   end

   always_ff @(posedge clock) begin
      job_ff     <= job_in;
      bucket_ff  <= bucket_in;
      cur_ff     <= cur_in;
      ok_ff      <= ok_in;
      steps_ff   <= steps_in;
      link_ff    <= link_in;
      status_ff  <= status_in;
      key_out_ff <= key_out_in;
      va_ff      <= va_in;
      vb_ff      <= vb_in;
      vc_ff      <= vc_in;
      pos_ff     <= pos_in;
      count_ff   <= count_in;
      if (reset) begin
         state_ff     <= S_INIT;
         fill_ff      <= '0;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

FILE: sv/chained_hash_dictionary_top.sv
// Top level of the chained hash dictionary: front queue, modulo unit, back end.
// Depends on chd_pkg, chd_ifs, chd_front, chd_mod, chd_back.
//
// Insert and find reduce the key sum in the bit-serial modulo unit, read the
// bucket head, then walk the chain, each node taking a memory read and a key
// compare. Read fetches one node; clear sweeps the bucket heads (one bucket
// head per cycle). After reset the head store is swept, during which no request
// transaction is accepted; csr writes are accepted at any time. A two-entry
// queue takes requests while the back end works; one transaction is executed
// at a time.
module chained_hash_dictionary_top (
   input  logic                       clock,
   input  logic                       reset,
   chd_req_if.sink                    req_chan,
   chd_rsp_if.source                  rsp_chan,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [chd_pkg::HSZ_W-1:0]  csr_data
);
   logic                  ready_en;
   logic                  job_valid;
   logic                  job_ready;
   chd_pkg::job_type      job;
   chd_pkg::mod_req_type  mod_req;
   chd_pkg::mod_rsp_type  mod_rsp;

   chd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (ready_en),
      .req_chan  (req_chan),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job       (job)
   );

   chd_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .mod_req   (mod_req),
      .mod_rsp   (mod_rsp)
   );

   chd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .ready_en  (ready_en),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job       (job),
      .mod_req   (mod_req),
      .mod_rsp   (mod_rsp),
      .rsp_chan  (rsp_chan)
   );
endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for chained_hash_dictionary_top.
// Depends on chd_pkg, chd_ifs and the block; keeps its own copy of the table
// and checks every response transaction against it.
module tb;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic [chd_pkg::HSZ_W-1:0] csr_data = '0;
   logic csr_ready;

   chd_req_if req_chan();
   chd_rsp_if rsp_chan();

   chained_hash_dictionary_top u_top (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   typedef struct packed {
      chd_pkg::status_type          status;
      logic [chd_pkg::KEY_W-1:0]    key;
      logic [chd_pkg::VAL_W-1:0]    va;
      logic [chd_pkg::VAL_W-1:0]    vb;
      logic [chd_pkg::VAL_W-1:0]    vc;
      logic [chd_pkg::POS_W-1:0]    pos;
      logic [chd_pkg::ENT_W-1:0]    count;
   } dict_rsp_type;

   // table model
   logic [chd_pkg::HSZ_W-1:0]  buckets_cfg;
   logic [chd_pkg::NODE_W-1:0] head_idx [chd_pkg::BUCKETS];
   logic                       head_ok [chd_pkg::BUCKETS];
   logic [chd_pkg::KEY_W-1:0]  node_key [chd_pkg::NODES];
   logic [chd_pkg::NODE_W-1:0] node_next [chd_pkg::NODES];
   logic                       next_ok [chd_pkg::NODES];
   logic [chd_pkg::VAL_W-1:0]  node_val [chd_pkg::NODES*3];
   int unsigned fill;

   dict_rsp_type pending_rsp[$];
   int errors = 0;
   int rsp_seen = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   logic hold_on = 1'b0;
   event hold_go;
   longint cycle = 0;
   logic [chd_pkg::KEY_W-1:0] known_keys[$];

   initial begin
      req_chan.valid = 1'b0;
      req_chan.command = '0;
      req_chan.key = '0;
      req_chan.value_a = '0;
      req_chan.value_b = '0;
      req_chan.value_c = '0;
      req_chan.position = '0;
      rsp_chan.ready = 1'b0;
   end

   function automatic int unsigned bucket_of(logic [chd_pkg::KEY_W-1:0] k);
      longint unsigned m;
      longint unsigned s;
      m = 64'(buckets_cfg);
      if (m == 0) m = 1;
      if (m > chd_pkg::BUCKETS) m = chd_pkg::BUCKETS;
      s = 64'(k[31:0]) + 64'(k[63:32]);
      return 32'(s % m);
   endfunction

   function automatic bit chain_find(logic [chd_pkg::KEY_W-1:0] k,
         output int unsigned idx);
      int unsigned b;
      int unsigned cur;
      bit ok;
      b = bucket_of(k);
      ok = head_ok[b];
      cur = 32'(head_idx[b]);
      idx = 0;
      for (int s = 0; s < chd_pkg::NODES && ok; s++) begin
         if (cur >= fill) return 0;
         if (node_key[cur] == k) begin
            idx = cur;
            return 1;
         end
         ok = next_ok[cur];
         cur = 32'(node_next[cur]);
      end
      return 0;
   endfunction

   function automatic dict_rsp_type entry_rsp(chd_pkg::status_type st, int unsigned idx,
         bit has);
      dict_rsp_type r;
      r = '0;
      r.status = st;
      if (has) begin
         r.key = node_key[idx];
         r.va = node_val[idx*3];
         r.vb = node_val[idx*3+1];
         r.vc = node_val[idx*3+2];
         r.pos = idx[chd_pkg::POS_W-1:0];
      end
      r.count = fill[chd_pkg::ENT_W-1:0];
      return r;
   endfunction

   function automatic dict_rsp_type dict_apply(chd_pkg::cmd_type c,
         logic [chd_pkg::KEY_W-1:0] k, logic [chd_pkg::VAL_W-1:0] a,
         logic [chd_pkg::VAL_W-1:0] b2, logic [chd_pkg::VAL_W-1:0] c2,
         logic [chd_pkg::POS_W-1:0] p);
      int unsigned idx;
      int unsigned b;
      case (c)
         chd_pkg::CMD_INSERT: begin
            if (chain_find(k, idx)) begin
               node_val[idx*3] = a; node_val[idx*3+1] = b2; node_val[idx*3+2] = c2;
               return entry_rsp(chd_pkg::ST_UPDATED, idx, 1);
            end else if (fill >= chd_pkg::NODES) begin
               return entry_rsp(chd_pkg::ST_FULL, 0, 0);
            end else begin
               b = bucket_of(k);
               idx = fill;
               node_key[idx] = k;
               node_val[idx*3] = a; node_val[idx*3+1] = b2; node_val[idx*3+2] = c2;
               node_next[idx] = head_idx[b];
               next_ok[idx] = head_ok[b];
               head_idx[b] = idx[chd_pkg::NODE_W-1:0];
               head_ok[b] = 1'b1;
               fill++;
               return entry_rsp(chd_pkg::ST_ADDED, idx, 1);
            end
         end
         chd_pkg::CMD_FIND: begin
            if (chain_find(k, idx)) return entry_rsp(chd_pkg::ST_FOUND, idx, 1);
            return entry_rsp(chd_pkg::ST_NOTFOUND, 0, 0);
         end
         chd_pkg::CMD_CLEAR: begin
            for (int i = 0; i < chd_pkg::BUCKETS; i++) begin
               head_ok[i] = 1'b0;
               head_idx[i] = '0;
            end
            for (int i = 0; i < chd_pkg::NODES; i++) next_ok[i] = 1'b0;
            fill = 0;
            return entry_rsp(chd_pkg::ST_CLEARED, 0, 0);
         end
         default: begin
            if (32'(p) < fill) return entry_rsp(chd_pkg::ST_READOK, 32'(p), 1);
            return entry_rsp(chd_pkg::ST_PASTEND, 0, 0);
         end
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch at response %0d: %s got %h expected %h", rsp_seen, what, got, want);
      errors++;
   endtask

   task automatic send_cmd(chd_pkg::cmd_type c, logic [chd_pkg::KEY_W-1:0] k,
         logic [chd_pkg::VAL_W-1:0] a, logic [chd_pkg::VAL_W-1:0] b2,
         logic [chd_pkg::VAL_W-1:0] c2, logic [chd_pkg::POS_W-1:0] p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.command <= c;
      req_chan.key <= k;
      req_chan.value_a <= a;
      req_chan.value_b <= b2;
      req_chan.value_c <= c2;
      req_chan.position <= p;
      do @(posedge clock); while (!req_chan.ready);
      pending_rsp.push_back(dict_apply(c, k, a, b2, c2, p));
      if (c == chd_pkg::CMD_INSERT) known_keys.push_back(k);
   endtask

   // response checker
   always @(posedge clock) begin
      dict_rsp_type w;
      cycle <= cycle + 1;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            $display("unexpected response transaction, status %0d", rsp_chan.status);
            errors++;
         end else begin
            w = pending_rsp.pop_front();
            if (rsp_chan.status !== w.status)
               report_mismatch("status", 64'(rsp_chan.status), 64'(w.status));
            if (rsp_chan.key_out !== w.key)
               report_mismatch("key", rsp_chan.key_out, w.key);
            if (rsp_chan.value_a_out !== w.va)
               report_mismatch("value_a", 64'(rsp_chan.value_a_out), 64'(w.va));
            if (rsp_chan.value_b_out !== w.vb)
               report_mismatch("value_b", 64'(rsp_chan.value_b_out), 64'(w.vb));
            if (rsp_chan.value_c_out !== w.vc)
               report_mismatch("value_c", 64'(rsp_chan.value_c_out), 64'(w.vc));
            if (rsp_chan.position_out !== w.pos)
               report_mismatch("position", 64'(rsp_chan.position_out), 64'(w.pos));
            if (rsp_chan.entry_count !== w.count)
               report_mismatch("entry_count", 64'(rsp_chan.entry_count), 64'(w.count));
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (hold_on) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // long receiver stall
   initial begin
      forever begin
         @(hold_go);
         hold_on <= 1'b1;
         repeat (400) @(posedge clock);
         hold_on <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (cycle > 3000000) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (chd_pkg::BUCKETS + 50) @(posedge clock);
   endtask

   task automatic write_hash_size(logic [chd_pkg::HSZ_W-1:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      buckets_cfg = v;
      csr_valid <= 1'b0;
   endtask

   function automatic logic [chd_pkg::KEY_W-1:0] rand_key();
      return {$urandom, $urandom};
   endfunction

   task automatic test_directed();
      send_cmd(chd_pkg::CMD_READ, '0, '0, '0, '0, '0);
      send_cmd(chd_pkg::CMD_FIND, '1, '0, '0, '0, '0);
      send_cmd(chd_pkg::CMD_INSERT, '0, '0, '0, '0, '0);
      send_cmd(chd_pkg::CMD_INSERT, '1, '1, '1, '1, '1);
      send_cmd(chd_pkg::CMD_INSERT, 64'h0000_0001_FFFF_FFFF, 32'hA5A5A5A5, 32'h5A5A5A5A,
               32'h1, '0);
      send_cmd(chd_pkg::CMD_INSERT, '1, 32'h12345678, 32'h0, 32'hFFFFFFFF, '0);
      send_cmd(chd_pkg::CMD_FIND, '1, '0, '0, '0, '0);
      send_cmd(chd_pkg::CMD_FIND, 64'h0000_0001_FFFF_FFFF, '0, '0, '0, '0);
      send_cmd(chd_pkg::CMD_FIND, 64'h1234, '0, '0, '0, '0);
      send_cmd(chd_pkg::CMD_READ, '0, '0, '0, '0, 10'd2);
      send_cmd(chd_pkg::CMD_READ, '0, '0, '0, '0, 10'd3);
      send_cmd(chd_pkg::CMD_READ, '0, '0, '0, '0, '1);
      send_cmd(chd_pkg::CMD_CLEAR, '1, '1, '1, '1, '1);
      send_cmd(chd_pkg::CMD_FIND, '1, '0, '0, '0, '0);
      send_cmd(chd_pkg::CMD_READ, '0, '0, '0, '0, '0);
      drain();
   endtask

   task automatic test_hash_sizes();
      // zero and oversize moduli, then a modulus change with entries held
      write_hash_size(11'd0);
      for (int i = 0; i < 6; i++)
         send_cmd(chd_pkg::CMD_INSERT, rand_key(), $urandom, $urandom, $urandom, '0);
      send_cmd(chd_pkg::CMD_FIND, known_keys[known_keys.size()-1], '0, '0, '0, '0);
      drain();
      write_hash_size(11'h7FF);
      for (int i = 0; i < 6; i++)
         send_cmd(chd_pkg::CMD_FIND, known_keys[$urandom_range(known_keys.size()-1)],
                  '0, '0, '0, '0);
      drain();
      write_hash_size(11'd7);
      for (int i = 0; i < 4; i++)
         send_cmd(chd_pkg::CMD_FIND, known_keys[$urandom_range(known_keys.size()-1)],
                  '0, '0, '0, '0);
      send_cmd(chd_pkg::CMD_CLEAR, '0, '0, '0, '0, '0);
      drain();
   endtask

   task automatic test_full_store();
      write_hash_size(11'd1024);
      for (int i = 0; i < chd_pkg::NODES; i++)
         send_cmd(chd_pkg::CMD_INSERT, {$urandom, 22'd0, i[9:0]}, $urandom, $urandom,
                  $urandom, '0);
      send_cmd(chd_pkg::CMD_INSERT, '1, $urandom, $urandom, $urandom, '0);
      send_cmd(chd_pkg::CMD_INSERT, known_keys[known_keys.size()-5], 32'hFFFFFFFF, '0,
               '1, '0);
      send_cmd(chd_pkg::CMD_READ, '0, '0, '0, '0, '1);
      send_cmd(chd_pkg::CMD_CLEAR, '0, '0, '0, '0, '0);
      drain();
   endtask

   task automatic random_phase(int n, logic [chd_pkg::HSZ_W-1:0] hs);
      int r;
      logic [chd_pkg::KEY_W-1:0] k;
      write_hash_size(hs);
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         k = (known_keys.size() > 0 && $urandom_range(1)) ?
             known_keys[$urandom_range(known_keys.size()-1)] : rand_key();
         if (i == n / 2) -> hold_go;
         if (r < 45)
            send_cmd(chd_pkg::CMD_INSERT, k, $urandom, $urandom, $urandom, 10'($urandom));
         else if (r < 75)
            send_cmd(chd_pkg::CMD_FIND, k, $urandom, $urandom, $urandom, 10'($urandom));
         else if (r < 97)
            send_cmd(chd_pkg::CMD_READ, k, $urandom, $urandom, $urandom,
                     (fill > 0 && $urandom_range(3) != 0) ?
                     10'($urandom_range(fill-1)) : 10'($urandom));
         else
            send_cmd(chd_pkg::CMD_CLEAR, k, $urandom, $urandom, $urandom, 10'($urandom));
      end
      drain();
   endtask

   initial begin
      buckets_cfg = chd_pkg::HSZ_RESET;
      for (int i = 0; i < chd_pkg::BUCKETS; i++) begin
         head_ok[i] = 1'b0;
         head_idx[i] = '0;
      end
      for (int i = 0; i < chd_pkg::NODES; i++) next_ok[i] = 1'b0;
      fill = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 36;
      recv_idle_pct = 87;
      test_directed();
      test_hash_sizes();
      send_idle_pct = 87;
      recv_idle_pct = 36;
      random_phase(170, 11'd1);
      random_phase(170, 11'd13);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_full_store();
      random_phase(170, 11'd1024);
      $display("covered insert/update/find/clear/read, full store, hash sizes 0..2047");
      $display("%0d responses checked, %0d mismatches", rsp_seen, errors);
      if (errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule

FILE: chained_hash_dictionary_top.f
sv/chd_pkg.sv
sv/chd_ifs.sv
sv/chd_front.sv
sv/chd_mod.sv
sv/chd_back.sv
sv/chained_hash_dictionary_top.sv
tb/sv/tb.sv
